[hw/rtl/jce_pkg.sv]
// Shared types and constants for the joint cubic ease transition block.
// No dependencies; imported by jce_lane, jce_prog and the top level.
package jce_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_STEPS       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_COXA  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_FEMUR = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_TIBIA = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE    = 3'd4;

    // input opcodes
    localparam logic OP_ARM  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // progress field
    localparam int PROG_W = 7;
    localparam logic [PROG_W-1:0] PROG_ZERO = 7'd0;
    localparam logic [PROG_W-1:0] PROG_MIN  = 7'd1;
    localparam logic [PROG_W-1:0] PROG_FULL = 7'd100;
    localparam int PROG_SCALE = 200;
    localparam int PROG_CNT_W = 3;

    localparam int TOL_RESET = 82;

    // control from the sequencer to the serial dividers
    typedef struct packed {
        logic start;
        logic step;
    } lane_ctl_t;

endpackage

[hw/rtl/jce_lane.sv]
// One joint lane: origin + round(d * w / den) by a radix-2 serial divider.
// The multiply by w is folded into the division, one bit of |d| per cycle.
// Depends on jce_pkg.
module jce_lane #(
    parameter int AW = 16,
    parameter int CW = 12
) (
    input  logic                    clk,
    input  jce_pkg::lane_ctl_t      ctl,
    input  logic signed [AW-1:0]    target,
    input  logic signed [AW-1:0]    origin,
    input  logic [3*CW-1:0]         w,
    input  logic [3*CW-1:0]         den,
    output logic signed [AW-1:0]    angle
);
    import jce_pkg::*;

    localparam int DW = 3 * CW;

    logic [AW-1:0] mag_reg;
    logic          neg_reg;
    logic [DW-1:0] rem_reg;
    logic [AW-1:0] quo_reg;

    logic [AW:0]   diff;
    logic [DW+1:0] acc;
    logic [DW+1:0] den1;
    logic [DW+1:0] den2;
    logic [DW-1:0] rem_next;
    logic [1:0]    digit;
    logic          rnd;
    logic [AW:0]   qr;
    logic [AW:0]   sq;

    assign diff = {target[AW-1], target} - {origin[AW-1], origin};

    // rem < den and w <= den keep acc below 3*den, so the digit is 0, 1 or 2
    always_comb
    begin
        den1 = (DW+2)'(den);
        den2 = {1'b0, den, 1'b0};
        acc  = {1'b0, rem_reg, 1'b0} + (mag_reg[AW-1] ? (DW+2)'(w) : '0);
        if (acc >= den2)
        begin
            digit    = 2'd2;
            rem_next = DW'(acc - den2);
        end
        else if (acc >= den1)
        begin
            digit    = 2'd1;
            rem_next = DW'(acc - den1);
        end
        else
        begin
            digit    = 2'd0;
            rem_next = DW'(acc);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            neg_reg <= diff[AW];
            mag_reg <= diff[AW] ? AW'(-diff) : AW'(diff);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (ctl.step)
        begin
            mag_reg <= mag_reg << 1;
            rem_reg <= rem_next;
            quo_reg <= (quo_reg << 1) + AW'(digit);
        end
    end

    // round half away from zero on the magnitude
    assign rnd   = ({rem_reg, 1'b0} >= {1'b0, den});
    assign qr    = (AW+1)'(quo_reg) + (AW+1)'(rnd);
    assign sq    = neg_reg ? -qr : qr;
    assign angle = AW'({origin[AW-1], origin} + sq);

endmodule

[hw/rtl/jce_prog.sv]
// Progress divider: floor(num / den) over PROG_W restoring steps.
// Depends on jce_pkg.
module jce_prog #(
    parameter int CW = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  jce_pkg::lane_ctl_t          ctl,
    input  logic [CW+8:0]               num,
    input  logic [CW:0]                 den,
    output logic [jce_pkg::PROG_W-1:0]  quo
);
    import jce_pkg::*;

    localparam int NW = CW + 9;

    logic [NW-1:0]         rem_reg;
    logic [PROG_W-1:0]     nb_reg;
    logic [PROG_W-1:0]     quo_reg;
    logic [PROG_CNT_W-1:0] cnt_reg;
    logic [NW:0]           trial;
    logic                  fits;

    assign trial = {rem_reg, nb_reg[PROG_W-1]};
    assign fits  = (trial >= (NW+1)'(den));
    assign quo   = quo_reg;

    // quotient only matters up to 100, so PROG_W bits cover it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            nb_reg  <= '0;
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (ctl.start)
        begin
            rem_reg <= num >> PROG_W;
            nb_reg  <= num[PROG_W-1:0];
            quo_reg <= '0;
            cnt_reg <= '0;
        end
        else if (ctl.step && (cnt_reg != PROG_CNT_W'(PROG_W)))
        begin
            rem_reg <= fits ? NW'(trial - (NW+1)'(den)) : NW'(trial);
            quo_reg <= {quo_reg[PROG_W-2:0], fits};
            nb_reg  <= nb_reg << 1;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule

[hw/rtl/joint_cubic_ease_transition.sv]
// Top level: cubic ease-in-out of three joint angles toward configured targets.
// Depends on jce_pkg, jce_lane (one per joint) and jce_prog.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+------------------------------------------
//   cfg      | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//   in       | in  | in_valid/in_stall   | opcode, current_coxa/femur/tibia
//   out      | out | out_valid/out_stall | progress, angles_valid, out_coxa/femur/tibia
//
// Arm beats, idle ticks and at-target ticks go from idle straight to the output
// state. A moving tick passes three multiply stages, then the three joint lanes
// retire one bit of |target - origin| per cycle.
// One beat is in flight at a time; the next is taken once the result sits in the
// output register, which may itself be held by out_stall.
// Reset returns control, config and output registers to idle, steps 1 and tolerance 82.
module joint_cubic_ease_transition #(
    parameter int ANGLE_WIDTH = 16,
    parameter int COUNT_WIDTH = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [jce_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [((ANGLE_WIDTH > COUNT_WIDTH) ? ANGLE_WIDTH : COUNT_WIDTH)-1:0] cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   opcode,
    input  logic signed [ANGLE_WIDTH-1:0]          current_coxa,
    input  logic signed [ANGLE_WIDTH-1:0]          current_femur,
    input  logic signed [ANGLE_WIDTH-1:0]          current_tibia,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [jce_pkg::PROG_W-1:0]             progress,
    output logic                                   angles_valid,
    output logic signed [ANGLE_WIDTH-1:0]          out_coxa,
    output logic signed [ANGLE_WIDTH-1:0]          out_femur,
    output logic signed [ANGLE_WIDTH-1:0]          out_tibia
);
    import jce_pkg::*;

    localparam int AW  = ANGLE_WIDTH;
    localparam int CW  = COUNT_WIDTH;
    localparam int DW  = 3 * CW;
    localparam int KW  = CW + 2;
    localparam int PNW = CW + 9;
    localparam int PDW = CW + 1;
    localparam int DCW = $clog2(AW);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t               state_reg;
    logic                 pending_reg;
    logic                 awaiting_reg;
    logic [CW-1:0]        tick_reg;
    logic signed [AW-1:0] origin_reg [3];
    logic signed [AW-1:0] target_reg [3];
    logic [CW-1:0]        steps_reg;
    logic [AW-2:0]        tol_reg;
    logic                 lanes_reg;
    logic                 last_reg;
    logic [PROG_W-1:0]    imm_prog_reg;
    logic [DCW-1:0]       dcnt_reg;

    logic                 out_valid_reg;
    logic [PROG_W-1:0]    progress_reg;
    logic                 angles_valid_reg;
    logic signed [AW-1:0] out_ang_reg [3];

    // arithmetic pipeline, no reset
    logic [CW-1:0]        n_reg;
    logic [CW-1:0]        c_reg;
    logic [2*CW-1:0]      csq_reg;
    logic [2*CW-1:0]      nsq_reg;
    logic [KW-1:0]        k_reg;
    logic [PNW-1:0]       pnum_reg;
    logic [PDW-1:0]       pden_reg;
    logic [CW+KW-1:0]     wlo_reg;
    logic [CW+KW-1:0]     whi_reg;
    logic [2*CW-1:0]      dlo_reg;
    logic [2*CW-1:0]      dhi_reg;
    logic [DW-1:0]        w_reg;
    logic [DW-1:0]        den_reg;

    logic signed [AW-1:0] cur [3];
    logic signed [AW-1:0] lane_ang [3];
    logic [2:0]           near;
    logic                 in_acc;
    logic                 out_take;
    logic                 out_load;
    logic [CW-1:0]        n_eff;
    logic [CW-1:0]        tc_new;
    logic [CW-1:0]        c_new;
    logic [PROG_W-1:0]    prog_q;
    logic [PROG_W-1:0]    prog_fin;
    logic [DW+1:0]        wsum;
    logic [DW-1:0]        dsum;
    lane_ctl_t            ctl;

    assign cur[0] = current_coxa;
    assign cur[1] = current_femur;
    assign cur[2] = current_tibia;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    assign out_valid    = out_valid_reg;
    assign progress     = progress_reg;
    assign angles_valid = angles_valid_reg;
    assign out_coxa     = out_ang_reg[0];
    assign out_femur    = out_ang_reg[1];
    assign out_tibia    = out_ang_reg[2];

    always_comb
    begin
        logic [AW:0] d;
        logic [AW:0] m;
        for (int j = 0; j < 3; j++)
        begin
            d       = {target_reg[j][AW-1], target_reg[j]} - {cur[j][AW-1], cur[j]};
            m       = d[AW] ? -d : d;
            near[j] = (m < (AW+1)'(tol_reg));
        end
    end

    assign n_eff  = (steps_reg == '0) ? CW'(1) : steps_reg;
    assign tc_new = (awaiting_reg ? '0 : tick_reg) + CW'(1);
    assign c_new  = (tc_new > n_eff) ? n_eff : tc_new;

    assign wsum = {whi_reg, {CW{1'b0}}} + (DW+2)'(wlo_reg);
    assign dsum = {dhi_reg, {CW{1'b0}}} + DW'(dlo_reg);

    assign ctl.start = (state_reg == ST_MUL3);
    assign ctl.step  = (state_reg == ST_DIV);

    // merge: progress clamp and final-tick override
    always_comb
    begin
        if (last_reg)
            prog_fin = PROG_FULL;
        else if (prog_q < PROG_MIN)
            prog_fin = PROG_MIN;
        else if (prog_q > PROG_FULL)
            prog_fin = PROG_FULL;
        else
            prog_fin = prog_q;
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        jce_lane #(
            .AW (AW),
            .CW (CW)
        ) u_lane (
            .clk    (clk),
            .ctl    (ctl),
            .target (target_reg[g]),
            .origin (origin_reg[g]),
            .w      (w_reg),
            .den    (den_reg),
            .angle  (lane_ang[g])
        );
    end

    jce_prog #(
        .CW (CW)
    ) u_prog (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .num   (pnum_reg),
        .den   (pden_reg),
        .quo   (prog_q)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_acc)
        begin
            n_reg <= n_eff;
            c_reg <= c_new;
        end
        if (state_reg == ST_MUL1)
        begin
            csq_reg  <= (2*CW)'(c_reg) * (2*CW)'(c_reg);
            nsq_reg  <= (2*CW)'(n_reg) * (2*CW)'(n_reg);
            k_reg    <= KW'(n_reg) + KW'({n_reg, 1'b0}) - KW'({c_reg, 1'b0});
            pnum_reg <= PNW'(tick_reg - CW'(1)) * PNW'(PROG_SCALE) + PNW'(n_reg);
            pden_reg <= {n_reg, 1'b0};
        end
        if (state_reg == ST_MUL2)
        begin
            wlo_reg <= (CW+KW)'(csq_reg[CW-1:0]) * (CW+KW)'(k_reg);
            whi_reg <= (CW+KW)'(csq_reg[2*CW-1:CW]) * (CW+KW)'(k_reg);
            dlo_reg <= (2*CW)'(nsq_reg[CW-1:0]) * (2*CW)'(n_reg);
            dhi_reg <= (2*CW)'(nsq_reg[2*CW-1:CW]) * (2*CW)'(n_reg);
        end
        if (state_reg == ST_MUL3)
        begin
            // both sums stay at or below n^3
            w_reg   <= DW'(wsum);
            den_reg <= dsum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            pending_reg      <= 1'b0;
            awaiting_reg     <= 1'b1;
            tick_reg         <= '0;
            steps_reg        <= CW'(1);
            tol_reg          <= (AW-1)'(TOL_RESET);
            lanes_reg        <= 1'b0;
            last_reg         <= 1'b0;
            imm_prog_reg     <= '0;
            dcnt_reg         <= '0;
            out_valid_reg    <= 1'b0;
            progress_reg     <= '0;
            angles_valid_reg <= 1'b0;
            for (int j = 0; j < 3; j++)
            begin
                origin_reg[j]  <= '0;
                target_reg[j]  <= '0;
                out_ang_reg[j] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_STEPS:        steps_reg     <= cfg_data[CW-1:0];
                    REG_TARGET_COXA:  target_reg[0] <= cfg_data[AW-1:0];
                    REG_TARGET_FEMUR: target_reg[1] <= cfg_data[AW-1:0];
                    REG_TARGET_TIBIA: target_reg[2] <= cfg_data[AW-1:0];
                    REG_TOLERANCE:    tol_reg       <= cfg_data[AW-2:0];
                    default: ;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (opcode == OP_ARM)
                        begin
                            pending_reg  <= 1'b1;
                            awaiting_reg <= 1'b1;
                            lanes_reg    <= 1'b0;
                            imm_prog_reg <= PROG_ZERO;
                            state_reg    <= ST_OUT;
                        end
                        else if (!pending_reg)
                        begin
                            lanes_reg    <= 1'b0;
                            imm_prog_reg <= PROG_FULL;
                            state_reg    <= ST_OUT;
                        end
                        else if (awaiting_reg && (&near))
                        begin
                            for (int j = 0; j < 3; j++)
                                origin_reg[j] <= cur[j];
                            pending_reg  <= 1'b0;
                            lanes_reg    <= 1'b0;
                            imm_prog_reg <= PROG_FULL;
                            state_reg    <= ST_OUT;
                        end
                        else
                        begin
                            if (awaiting_reg)
                            begin
                                for (int j = 0; j < 3; j++)
                                    origin_reg[j] <= cur[j];
                            end
                            tick_reg  <= tc_new;
                            last_reg  <= (tc_new >= n_eff);
                            lanes_reg <= 1'b1;
                            if (tc_new >= n_eff)
                            begin
                                pending_reg  <= 1'b0;
                                awaiting_reg <= 1'b1;
                            end
                            else
                                awaiting_reg <= 1'b0;
                            state_reg <= ST_MUL1;
                        end
                    end
                end
                ST_MUL1: state_reg <= ST_MUL2;
                ST_MUL2: state_reg <= ST_MUL3;
                ST_MUL3:
                begin
                    dcnt_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DCW'(AW - 1))
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        progress_reg     <= lanes_reg ? prog_fin : imm_prog_reg;
                        angles_valid_reg <= lanes_reg;
                        for (int j = 0; j < 3; j++)
                            out_ang_reg[j] <= lanes_reg ? lane_ang[j] : '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // no transition running means the next one must latch its origin
    a_idle_needs_origin: assert property (@(posedge clk) disable iff (!rst_n)
        !pending_reg |-> awaiting_reg)
        else $error("transition idle without first-tick flag");

    // arm beats never enter the arithmetic path
    a_arm_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && opcode == OP_ARM) |=> (state_reg == ST_OUT))
        else $error("arm beat did not go straight to output");

    a_prog_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && angles_valid) |-> (progress >= PROG_MIN && progress <= PROG_FULL))
        else $error("progress out of range on an angle result");

    a_quiet_angles: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !angles_valid) |->
            (out_coxa == '0 && out_femur == '0 && out_tibia == '0))
        else $error("angles nonzero on a result without angles");

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for joint_cubic_ease_transition (cubic ease of three joints).
// Depends on jce_pkg and the RTL top level; results are predicted here from a local
// model of the transition state and checked beat by beat as they leave the block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jce_pkg::*;

    localparam int ANGLE_W = 16;
    localparam int COUNT_W = 12;
    localparam int DATA_W = 16;
    localparam int JOINTS = 3;
    localparam int DRAIN_CYCLES = 40;
    localparam longint ANGLE_MAX = (longint'(1) << (ANGLE_W - 1)) - 1;
    localparam longint ANGLE_MIN = -(longint'(1) << (ANGLE_W - 1));

    typedef logic signed [ANGLE_W-1:0] angle_t;

    typedef struct packed {
        logic [PROG_W-1:0] progress;
        logic              angles_valid;
        angle_t            coxa;
        angle_t            femur;
        angle_t            tibia;
    } pose_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic                   opcode = OP_TICK;
    angle_t                 current_coxa = '0;
    angle_t                 current_femur = '0;
    angle_t                 current_tibia = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [PROG_W-1:0]      progress;
    logic                   angles_valid;
    angle_t                 out_coxa;
    angle_t                 out_femur;
    angle_t                 out_tibia;

    // mirror of the block's registers and transition state
    logic [COUNT_W-1:0] steps_reg = COUNT_W'(1);
    angle_t             target_reg[JOINTS] = '{default: '0};
    logic [ANGLE_W-2:0] tol_reg = (ANGLE_W-1)'(TOL_RESET);
    bit                 moving = 1'b0;
    bit                 need_origin = 1'b1;
    logic [COUNT_W-1:0] tick_cnt = '0;
    angle_t             origin_pos[JOINTS] = '{default: '0};

    pose_t pose_q[$];

    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int reg_writes = 0;
    int moves_done = 0;
    int near_exits = 0;
    int sender_idle_pct = 12;
    int receiver_stall_pct = 50;
    int hold_request = 0;
    int hold_left = 0;

    joint_cubic_ease_transition u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .current_coxa (current_coxa),
        .current_femur(current_femur),
        .current_tibia(current_tibia),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .progress     (progress),
        .angles_valid (angles_valid),
        .out_coxa     (out_coxa),
        .out_femur    (out_femur),
        .out_tibia    (out_tibia)
    );

    always #5 clk = ~clk;

    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
        case (idx)
            REG_STEPS:        steps_reg = data[COUNT_W-1:0];
            REG_TARGET_COXA:  target_reg[0] = data[ANGLE_W-1:0];
            REG_TARGET_FEMUR: target_reg[1] = data[ANGLE_W-1:0];
            REG_TARGET_TIBIA: target_reg[2] = data[ANGLE_W-1:0];
            REG_TOLERANCE:    tol_reg = data[ANGLE_W-2:0];
            default:          ;
        endcase
    endfunction

    // Expected pose for one beat; advances the mirrored transition state.
    function automatic pose_t next_pose(logic op, angle_t c0, angle_t c1, angle_t c2);
        pose_t  r;
        angle_t cur[JOINTS];
        angle_t pos[JOINTS];
        bit     near;
        longint n, c, w, den, d, num, mag, q, v, pct;
        r = '0;
        cur[0] = c0;
        cur[1] = c1;
        cur[2] = c2;
        if (op == OP_ARM) begin
            moving = 1'b1;
            need_origin = 1'b1;
            r.progress = PROG_ZERO;
            return r;
        end
        r.progress = PROG_FULL;
        if (!moving)
            return r;
        if (need_origin) begin
            near = 1'b1;
            for (int j = 0; j < JOINTS; j++) begin
                origin_pos[j] = cur[j];
                d = longint'(target_reg[j]) - longint'(origin_pos[j]);
                if ((d < 0 ? -d : d) >= longint'(tol_reg))
                    near = 1'b0;
            end
            if (near) begin
                moving = 1'b0;
                near_exits++;
                return r;
            end
            need_origin = 1'b0;
            tick_cnt = '0;
        end
        n = (steps_reg == 0) ? 1 : longint'(steps_reg);
        tick_cnt = tick_cnt + 1'b1;
        c = longint'(tick_cnt);
        if (c > n)
            c = n;
        // t*t*(3-2t) scaled by N^3, rounded half away from zero
        w = c * c * (3 * n - 2 * c);
        den = n * n * n;
        for (int j = 0; j < JOINTS; j++) begin
            num = (longint'(target_reg[j]) - longint'(origin_pos[j])) * w;
            mag = num < 0 ? -num : num;
            q = (2 * mag + den) / (2 * den);
            v = longint'(origin_pos[j]) + (num < 0 ? -q : q);
            pos[j] = angle_t'(v);
        end
        pct = ((longint'(tick_cnt) - 1) * PROG_SCALE + n) / (2 * n);
        if (pct < longint'(PROG_MIN))
            pct = PROG_MIN;
        if (pct > longint'(PROG_FULL))
            pct = PROG_FULL;
        if (longint'(tick_cnt) >= n) begin
            moving = 1'b0;
            need_origin = 1'b1;
            pct = PROG_FULL;
            moves_done++;
        end
        r.progress = PROG_W'(pct);
        r.angles_valid = 1'b1;
        r.coxa = pos[0];
        r.femur = pos[1];
        r.tibia = pos[2];
        return r;
    endfunction

    function automatic angle_t rand_angle();
        return angle_t'($urandom());
    endfunction

    // a measured angle strictly inside the tolerance window around aim
    function automatic angle_t near_angle(angle_t aim);
        longint span, v;
        span = (tol_reg == 0) ? 0 : longint'(tol_reg) - 1;
        v = longint'(aim) + longint'($urandom_range(int'(2 * span))) - span;
        if (v > ANGLE_MAX)
            v = ANGLE_MAX;
        if (v < ANGLE_MIN)
            v = ANGLE_MIN;
        return angle_t'(v);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // one beat on the input channel; valid stays up afterwards for back-to-back beats
    task automatic send_item(logic op, angle_t c0, angle_t c1, angle_t c2);
        if (cfg_valid)
            cfg_valid <= 1'b0;
        while ($urandom_range(99) < sender_idle_pct) begin
            if (in_valid)
                in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        current_coxa <= c0;
        current_femur <= c1;
        current_tibia <= c2;
        do
            @(posedge clk);
        while (in_stall);
        pose_q.push_back(next_pose(op, c0, c1, c2));
        items_sent++;
    endtask

    // register writes only once every pending result has left the block
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [DATA_W-1:0] data);
        if (in_valid)
            in_valid <= 1'b0;
        while (pose_q.size() != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
        reg_writes++;
    endtask

    task automatic tick_random();
        send_item(OP_TICK, rand_angle(), rand_angle(), rand_angle());
    endtask

    // reset values: one step, zero targets, tolerance 82
    task automatic test_reset_state();
        send_item(OP_TICK, 16'sd1, 16'sd2, 16'sd3);
        send_item(OP_ARM, -16'sd1, -16'sd1, -16'sd1);
        send_item(OP_TICK, 16'sd81, -16'sd81, 16'sd0);
        send_item(OP_ARM, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_TICK, 16'sd82, 16'sd0, 16'sd0);
    endtask

    // full-scale swing between opposite rails, then a restart in the middle of a move
    task automatic test_full_swing();
        write_reg(REG_STEPS, 16'd4);
        write_reg(REG_TARGET_COXA, 16'h7FFF);
        write_reg(REG_TARGET_FEMUR, 16'h8000);
        write_reg(REG_TARGET_TIBIA, 16'h0000);
        write_reg(REG_TOLERANCE, 16'd0);
        send_item(OP_ARM, 16'sh0000, 16'sh0000, 16'sh0000);
        send_item(OP_TICK, 16'sh8000, 16'sh7FFF, 16'shFFFF);
        repeat (3)
            tick_random();
        send_item(OP_ARM, 16'sh7FFF, 16'sh8000, 16'sh0000);
        send_item(OP_TICK, 16'sh0000, 16'sh0000, 16'sh0000);
        send_item(OP_ARM, 16'sh1234, 16'shEDCB, 16'sh5555);
        send_item(OP_TICK, 16'sd100, -16'sd100, 16'sd5);
        while (moving)
            tick_random();
    endtask

    // zero and maximum step counts, widest tolerance, step count cut mid-move
    task automatic test_step_extremes();
        write_reg(REG_STEPS, 16'd0);
        send_item(OP_ARM, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_TICK, 16'sh4000, 16'shC000, 16'sh2AAA);
        write_reg(REG_STEPS, 16'd4095);
        write_reg(REG_TOLERANCE, 16'h7FFF);
        for (int j = 0; j < JOINTS; j++)
            write_reg(CFG_INDEX_W'(REG_TARGET_COXA + j), 16'h0000);
        send_item(OP_ARM, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_TICK, 16'sd16383, -16'sd16383, 16'sd0);
        write_reg(REG_TOLERANCE, 16'd0);
        send_item(OP_ARM, 16'sd0, 16'sd0, 16'sd0);
        send_item(OP_TICK, 16'sh8000, 16'sh8000, 16'sh8000);
        tick_random();
        // unused indexes must leave every register alone
        for (int k = REG_TOLERANCE + 1; k < 2 ** CFG_INDEX_W; k++)
            write_reg(CFG_INDEX_W'(k), 16'hFFFF);
        write_reg(REG_STEPS, 16'd2);
        tick_random();
    endtask

    // long receiver hold while beats keep coming, so the input side backs up
    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        write_reg(REG_STEPS, 16'd6);
        write_reg(REG_TARGET_COXA, 16'h1F00);
        write_reg(REG_TOLERANCE, 16'd0);
        hold_request = 300;
        send_item(OP_ARM, 16'sd0, 16'sd0, 16'sd0);
        repeat (6)
            tick_random();
        tick_random();
        send_item(OP_ARM, 16'sd0, 16'sd0, 16'sd0);
        tick_random();
    endtask

    // well-formed move with random configuration and content
    task automatic run_transition();
        int roll;
        int guard;
        roll = $urandom_range(99);
        if (roll < 75)
            write_reg(REG_STEPS, DATA_W'($urandom_range(1, 8)));
        else if (roll < 95)
            write_reg(REG_STEPS, DATA_W'($urandom_range(9, 40)));
        else
            write_reg(REG_STEPS, 16'd0);
        for (int j = 0; j < JOINTS; j++)
            if ($urandom_range(9) < 7)
                write_reg(CFG_INDEX_W'(REG_TARGET_COXA + j), DATA_W'($urandom()));
        roll = $urandom_range(99);
        if (roll < 60)
            write_reg(REG_TOLERANCE, DATA_W'($urandom_range(0, 400)));
        else if (roll < 80)
            write_reg(REG_TOLERANCE, DATA_W'($urandom()));
        else if (roll < 90)
            write_reg(REG_TOLERANCE, 16'd0);
        send_item(OP_ARM, rand_angle(), rand_angle(), rand_angle());
        if ($urandom_range(3) == 0)
            send_item(OP_TICK, near_angle(target_reg[0]), near_angle(target_reg[1]),
                      near_angle(target_reg[2]));
        else
            tick_random();
        guard = 0;
        while (moving && guard < 64) begin
            tick_random();
            guard++;
        end
    endtask

    task automatic run_noise();
        int count;
        count = $urandom_range(1, 4);
        repeat (count)
            send_item(($urandom_range(9) < 7) ? OP_TICK : OP_ARM,
                      rand_angle(), rand_angle(), rand_angle());
    endtask

    // move on a random step count up to 4095 that is disturbed, then forced to finish
    task automatic run_broken();
        int extra;
        int guard;
        write_reg(REG_STEPS, DATA_W'($urandom()));
        write_reg(REG_TOLERANCE, DATA_W'($urandom_range(0, 50)));
        send_item(OP_ARM, rand_angle(), rand_angle(), rand_angle());
        tick_random();
        extra = $urandom_range(0, 4);
        repeat (extra)
            tick_random();
        case ($urandom_range(2))
            0: write_reg(REG_STEPS, DATA_W'($urandom_range(0, 3)));
            1: begin
                write_reg(CFG_INDEX_W'(REG_TARGET_COXA + $urandom_range(JOINTS - 1)),
                          DATA_W'($urandom()));
                tick_random();
            end
            default: begin
                send_item(OP_ARM, rand_angle(), rand_angle(), rand_angle());
                tick_random();
            end
        endcase
        guard = 0;
        while (moving && guard < 8) begin
            tick_random();
            guard++;
        end
        if (moving) begin
            write_reg(REG_STEPS, DATA_W'($urandom_range(0, 2)));
            while (moving)
                tick_random();
        end
    endtask

    task automatic run_random_phase(int quota, int idle_pct, int stall_pct);
        int first;
        int roll;
        first = items_sent;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        while (items_sent - first < quota) begin
            roll = $urandom_range(99);
            if (roll < 65)
                run_transition();
            else if (roll < 85)
                run_noise();
            else
                run_broken();
        end
    endtask

    // output side: random stalls plus the occasional long hold
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        pose_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pose_q.size() == 0)
            begin
                errors++;
                $display("%0t ns: result beat with nothing expected, progress %0d", $time,
                         progress);
            end
            else
            begin
                want = pose_q.pop_front();
                results_seen++;
                check_field("progress", want.progress, progress);
                check_field("angles_valid", want.angles_valid, angles_valid);
                check_field("out_coxa", want.coxa, out_coxa);
                check_field("out_femur", want.femur, out_femur);
                check_field("out_tibia", want.tibia, out_tibia);
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_full_swing();
        test_step_extremes();
        test_backpressure();
        run_random_phase(190, 12, 50);
        run_random_phase(190, 50, 12);
        run_random_phase(170, 0, 0);
        if (in_valid)
            in_valid <= 1'b0;
        if (cfg_valid)
            cfg_valid <= 1'b0;
        while (pose_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d input beats and %0d result beats with %0d register writes over",
                 items_sent, results_seen, reg_writes);
        $display("three stall mixes: %0d moves reached target, %0d ended at target at once.",
                 moves_done, near_exits);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timed out with %0d results still expected", pose_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
